@@ rtl/lrns_pkg.sv @@
package lrns_pkg;

    // Field widths fixed by the scan and result formats
    localparam int unsigned TimeW    = 32;
    localparam int unsigned IntvW    = 16;
    localparam int unsigned FailW    = 8;
    localparam int unsigned CfgAddrW = 5;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW  = 72;
    localparam int unsigned OutDataW = 32;

    // Register map, one word per register
    typedef enum logic [2:0] {
        REG_STALE_TIMEOUT   = 3'd0,
        REG_STABLE_INTERVAL = 3'd1,
        REG_FAST_INTERVAL   = 3'd2,
        REG_MID_INTERVAL    = 3'd3,
        REG_SLOW_INTERVAL   = 3'd4,
        REG_PRIMARY_PERIOD  = 3'd5,
        REG_POWER_PERIOD    = 3'd6,
        REG_CADENCE_PERIOD  = 3'd7
    } t_reg_idx;

    // Register values after reset
    localparam logic [IntvW-1:0] RstStaleTimeout   = 16'd1800;
    localparam logic [IntvW-1:0] RstStableInterval = 16'd1500;
    localparam logic [IntvW-1:0] RstFastInterval   = 16'd750;
    localparam logic [IntvW-1:0] RstMidInterval    = 16'd2000;
    localparam logic [IntvW-1:0] RstSlowInterval   = 16'd3500;
    localparam logic [IntvW-1:0] RstPrimaryPeriod  = 16'd200;
    localparam logic [IntvW-1:0] RstPowerPeriod    = 16'd1000;
    localparam logic [IntvW-1:0] RstCadencePeriod  = 16'd1500;

    typedef struct packed {
        logic [IntvW-1:0] stale_timeout;
        logic [IntvW-1:0] stable_interval;
        logic [IntvW-1:0] fast_interval;
        logic [IntvW-1:0] mid_interval;
        logic [IntvW-1:0] slow_interval;
        logic [IntvW-1:0] primary_period;
        logic [IntvW-1:0] power_period;
        logic [IntvW-1:0] cadence_period;
    } t_cfg;

    typedef struct packed {
        logic [TimeW-1:0] now_ms;
        logic [TimeW-1:0] data_stamp;
        logic             trainer_linked;
        logic             heart_linked;
        logic             cadence_linked;
        logic             primary_client;
        logic             power_client;
        logic             cadence_client;
    } t_scan;

    typedef struct packed {
        logic             clear_data;
        logic             is_stale;
        logic             connect_trainer;
        logic             connect_heart;
        logic             connect_cadence;
        logic             send_primary;
        logic             send_power;
        logic             send_cadence;
        logic [FailW-1:0] failures;
        logic [IntvW-1:0] retry_interval;
    } t_result;

endpackage

@@ rtl/lrns_cfg.sv @@
module lrns_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrns_pkg::CfgAddrW-1:0]    paddr,
    input  logic [lrns_pkg::CfgDataW-1:0]    pwdata,
    output logic [lrns_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready,
    output lrns_pkg::t_cfg                   o_cfg
);
    import lrns_pkg::*;

    t_cfg             r_cfg;
    t_reg_idx         reg_idx;
    logic             wr_en;
    logic [IntvW-1:0] wr_val;
    logic [IntvW-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign wr_val  = pwdata[IntvW-1:0];

    // Register file, written in the access phase of a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stale_timeout   <= RstStaleTimeout;
            r_cfg.stable_interval <= RstStableInterval;
            r_cfg.fast_interval   <= RstFastInterval;
            r_cfg.mid_interval    <= RstMidInterval;
            r_cfg.slow_interval   <= RstSlowInterval;
            r_cfg.primary_period  <= RstPrimaryPeriod;
            r_cfg.power_period    <= RstPowerPeriod;
            r_cfg.cadence_period  <= RstCadencePeriod;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STALE_TIMEOUT:   r_cfg.stale_timeout   <= wr_val;
                REG_STABLE_INTERVAL: r_cfg.stable_interval <= wr_val;
                REG_FAST_INTERVAL:   r_cfg.fast_interval   <= wr_val;
                REG_MID_INTERVAL:    r_cfg.mid_interval    <= wr_val;
                REG_SLOW_INTERVAL:   r_cfg.slow_interval   <= wr_val;
                REG_PRIMARY_PERIOD:  r_cfg.primary_period  <= wr_val;
                REG_POWER_PERIOD:    r_cfg.power_period    <= wr_val;
                REG_CADENCE_PERIOD:  r_cfg.cadence_period  <= wr_val;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer
    always_comb begin
        unique case (reg_idx)
            REG_STALE_TIMEOUT:   rd_val = r_cfg.stale_timeout;
            REG_STABLE_INTERVAL: rd_val = r_cfg.stable_interval;
            REG_FAST_INTERVAL:   rd_val = r_cfg.fast_interval;
            REG_MID_INTERVAL:    rd_val = r_cfg.mid_interval;
            REG_SLOW_INTERVAL:   rd_val = r_cfg.slow_interval;
            REG_PRIMARY_PERIOD:  rd_val = r_cfg.primary_period;
            REG_POWER_PERIOD:    rd_val = r_cfg.power_period;
            REG_CADENCE_PERIOD:  rd_val = r_cfg.cadence_period;
            default:             rd_val = '0;
        endcase
    end

    assign prdata = {{(CfgDataW-IntvW){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

@@ rtl/lrns_core.sv @@
module lrns_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lrns_pkg::t_scan   i_scan,
    input  lrns_pkg::t_cfg    i_cfg,
    output lrns_pkg::t_result o_result
);
    import lrns_pkg::*;

    localparam logic [FailW-1:0] FailMax     = {FailW{1'b1}};
    localparam logic [FailW-1:0] SlowTierMin = 8'd5;
    localparam logic [FailW-1:0] MidTierMin  = 8'd2;

    // Scheduler state
    logic [TimeW-1:0] r_last_data, r_last_check;
    logic [TimeW-1:0] r_last_pri, r_last_pow, r_last_cad;
    logic [IntvW-1:0] r_interval;
    logic [FailW-1:0] r_fail;
    logic             r_stale;

    logic [TimeW-1:0] n_last_data, n_last_check;
    logic [TimeW-1:0] n_last_pri, n_last_pow, n_last_cad;
    logic [IntvW-1:0] n_interval;
    logic [FailW-1:0] n_fail;
    logic             n_stale;

    logic [TimeW-1:0] data_age, check_age, pri_age, pow_age, cad_age;
    logic             stale_hit, new_data, check_due, pri_due, pow_due, cad_due;
    logic             clear, c_tr;
    logic [IntvW-1:0] int_a, int_b;
    logic [FailW-1:0] fail_a, fail_b;

    function automatic logic [FailW-1:0] sat_inc(input logic [FailW-1:0] val);
        sat_inc = (val == FailMax) ? val : val + 1'b1;
    endfunction

    // Ages of the data and of each timer, modulo the time word
    assign data_age  = i_scan.now_ms - r_last_data;
    assign check_age = i_scan.now_ms - r_last_check;
    assign pri_age   = i_scan.now_ms - r_last_pri;
    assign pow_age   = i_scan.now_ms - r_last_pow;
    assign cad_age   = i_scan.now_ms - r_last_cad;

    assign stale_hit = data_age > {{(TimeW-IntvW){1'b0}}, i_cfg.stale_timeout};
    assign new_data  = i_scan.data_stamp > r_last_data;
    assign pri_due   = pri_age >= {{(TimeW-IntvW){1'b0}}, i_cfg.primary_period};
    assign pow_due   = pow_age >= {{(TimeW-IntvW){1'b0}}, i_cfg.power_period};
    assign cad_due   = cad_age >= {{(TimeW-IntvW){1'b0}}, i_cfg.cadence_period};

    // Stale entry, then fresh data, then the retry check
    always_comb begin
        clear   = 1'b0;
        n_stale = r_stale;
        fail_a  = r_fail;
        int_a   = r_interval;
        if (stale_hit) begin
            if (!r_stale) begin
                clear   = 1'b1;
                n_stale = 1'b1;
                fail_a  = sat_inc(r_fail);
                int_a   = i_cfg.fast_interval;
            end
        end else begin
            n_stale = 1'b0;
        end

        n_last_data = r_last_data;
        fail_b      = fail_a;
        int_b       = int_a;
        if (new_data) begin
            n_last_data = i_scan.data_stamp;
            fail_b      = '0;
            int_b       = i_cfg.stable_interval;
        end

        // The retry check runs on the interval left by the two steps above
        check_due    = check_age >= {{(TimeW-IntvW){1'b0}}, int_b};
        c_tr         = 1'b0;
        n_fail       = fail_b;
        n_interval   = int_b;
        n_last_check = r_last_check;
        if (check_due) begin
            n_last_check = i_scan.now_ms;
            if (!i_scan.trainer_linked) begin
                c_tr   = 1'b1;
                n_fail = sat_inc(fail_b);
                if (n_fail > SlowTierMin) begin
                    n_interval = i_cfg.slow_interval;
                end else if (n_fail > MidTierMin) begin
                    n_interval = i_cfg.mid_interval;
                end else begin
                    n_interval = i_cfg.fast_interval;
                end
            end else if (fail_b != '0) begin
                n_fail     = '0;
                n_interval = i_cfg.stable_interval;
            end
        end
    end

    // Notification timers restart whenever they fire
    assign n_last_pri = pri_due ? i_scan.now_ms : r_last_pri;
    assign n_last_pow = pow_due ? i_scan.now_ms : r_last_pow;
    assign n_last_cad = cad_due ? i_scan.now_ms : r_last_cad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_data  <= '0;
            r_last_check <= '0;
            r_last_pri   <= '0;
            r_last_pow   <= '0;
            r_last_cad   <= '0;
            r_interval   <= RstStableInterval;
            r_fail       <= '0;
            r_stale      <= 1'b0;
        end else if (i_fire) begin
            r_last_data  <= n_last_data;
            r_last_check <= n_last_check;
            r_last_pri   <= n_last_pri;
            r_last_pow   <= n_last_pow;
            r_last_cad   <= n_last_cad;
            r_interval   <= n_interval;
            r_fail       <= n_fail;
            r_stale      <= n_stale;
        end
    end

    // Result of the scan being processed
    always_comb begin
        o_result.clear_data      = clear;
        o_result.is_stale        = n_stale;
        o_result.connect_trainer = c_tr;
        o_result.connect_heart   = check_due & ~i_scan.heart_linked;
        o_result.connect_cadence = check_due & ~i_scan.cadence_linked;
        o_result.send_primary    = pri_due & i_scan.primary_client & ~n_stale;
        o_result.send_power      = pow_due & i_scan.power_client;
        o_result.send_cadence    = cad_due & i_scan.cadence_client;
        o_result.failures        = n_fail;
        o_result.retry_interval  = n_interval;
    end

endmodule

@@ rtl/link_reconnect_notify_scheduler.sv @@
// Link reconnect and notify scheduler.
// Each item on the slave stream is one scan: the current millisecond time,
// the newest trainer data time and six link and client flags. For every
// scan one result item leaves on the master stream with the clear-data
// pulse, the stale flag, three reconnect requests, three send requests,
// the failure count and the current retry interval.
// An accepted item is held in an input register; when the result stage
// is free the scan logic updates the scheduler state and loads the result
// register, from which the receiver takes the result. One item is taken
// every cycle while the receiver does not stall; the rate holds because
// the scan logic updates the state registers as it loads the result
// register.
// When the receiver stalls the result register holds its item and the
// input register still takes one more item; after that s_axis_tready
// falls until the result is taken.
// Reset clears both stages, the timers, the failure count and the stale
// flag, loads the retry interval with the stable interval's reset value and
// returns all configuration registers to their reset values. The APB port
// holds the eight 16-bit registers at byte addresses 0 to 28.
module link_reconnect_notify_scheduler (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // now_ms[31:0], data_stamp[63:32], trainer_linked[64], heart_linked[65],
    // cadence_linked[66], primary_client[67], power_client[68],
    // cadence_client[69], zero padding[71:70]
    input  logic [lrns_pkg::InDataW-1:0]     s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // clear_data[0], is_stale[1], connect_trainer[2], connect_heart[3],
    // connect_cadence[4], send_primary[5], send_power[6], send_cadence[7],
    // failures[15:8], retry_interval[31:16]
    output logic [lrns_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lrns_pkg::CfgAddrW-1:0]    paddr,
    input  logic [lrns_pkg::CfgDataW-1:0]    pwdata,
    output logic [lrns_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready
);
    import lrns_pkg::*;

    t_cfg    cfg;
    t_scan   r_in;
    t_result r_out;
    t_result result;
    logic    r_in_vld, r_out_vld;
    logic    advance, fire, in_take;

    lrns_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Pipeline handshake: the result stage frees when empty or taken
    assign advance       = ~r_out_vld | m_axis_tready;
    assign fire          = r_in_vld & advance;
    assign s_axis_tready = ~r_in_vld | advance;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Input register, unpacked from the stream word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.now_ms         <= s_axis_tdata[31:0];
            r_in.data_stamp     <= s_axis_tdata[63:32];
            r_in.trainer_linked <= s_axis_tdata[64];
            r_in.heart_linked   <= s_axis_tdata[65];
            r_in.cadence_linked <= s_axis_tdata[66];
            r_in.primary_client <= s_axis_tdata[67];
            r_in.power_client   <= s_axis_tdata[68];
            r_in.cadence_client <= s_axis_tdata[69];
        end
    end

    lrns_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_scan   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out.retry_interval, r_out.failures,
                            r_out.send_cadence, r_out.send_power, r_out.send_primary,
                            r_out.connect_cadence, r_out.connect_heart,
                            r_out.connect_trainer, r_out.is_stale, r_out.clear_data};

endmodule

@@ rtl/lrns_checker.sv @@
module lrns_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lrns_pkg::OutDataW-1:0] m_axis_tdata
);
    import lrns_pkg::*;

    // No result is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

    // A stalled result keeps its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The clear pulse only comes with the stale flag set
    a_clear_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("clear_data without is_stale");

    // A trainer reconnect always leaves a nonzero failure count
    a_retry_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[15:8] != 8'd0)
        else $error("trainer reconnect with zero failure count");

    // The primary send is blocked while stale
    a_primary_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[1])
        else $error("primary send while stale");

endmodule

bind link_reconnect_notify_scheduler lrns_checker u_lrns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
